// ===== hw/rtl/spc_pkg.sv =====
// Shared types, register map and constants of the speaker protection controller.
package spc_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [15:0] SAMPLE_INTERVAL = 16'd10;
	localparam logic [11:0] TEMP_CODE_MIN   = 12'd1;
	localparam logic [11:0] TEMP_CODE_MAX   = 12'd4094;
	localparam logic [15:0] SAT16           = 16'hFFFF;

	// fault bit masks
	localparam logic [3:0] FLT_SENSOR_ONE = 4'b0001;
	localparam logic [3:0] FLT_SENSOR_TWO = 4'b0010;
	localparam logic [3:0] FLT_HOT        = 4'b0100;
	localparam logic [3:0] FLT_DC_OFFSET  = 4'b1000;
	localparam logic [3:0] FLT_ADC        = FLT_SENSOR_ONE | FLT_SENSOR_TWO | FLT_DC_OFFSET;

	typedef enum logic [2:0] {
		REG_STARTUP_DELAY = 3'd0,
		REG_DC_TRIP_LEVEL = 3'd1,
		REG_DC_FAST_LEVEL = 3'd2,
		REG_DC_SAFE_LEVEL = 3'd3,
		REG_DC_TRIP_TIME  = 3'd4,
		REG_DC_FAST_TIME  = 3'd5,
		REG_OVERTEMP      = 3'd6,
		REG_COOL_RESET    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] startup_delay;
		logic [15:0] dc_trip_level;
		logic [15:0] dc_fast_trip_level;
		logic [15:0] dc_safe_level;
		logic [15:0] dc_trip_ticks;
		logic [15:0] dc_fast_ticks;
		logic [11:0] overtemp_level;
		logic [11:0] cool_reset_level;
	} cfg_t;

	typedef struct packed {
		logic               mute_pressed;
		logic               reset_pressed;
		logic               adc_ok;
		logic [11:0]        temp_one;
		logic [11:0]        temp_two;
		logic signed [15:0] dc_left;
		logic signed [15:0] dc_right;
	} tick_word_t;

	typedef struct packed {
		logic       speakers_on;
		logic [3:0] fault_bits;
		logic       startup_pending;
	} status_word_t;

endpackage

// ===== hw/rtl/spc_if.sv =====
// Valid/ready channel interfaces for tick and status words.
interface spc_tick_if;
	logic               valid;
	logic               ready;
	spc_pkg::tick_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface spc_status_if;
	logic                 valid;
	logic                 ready;
	spc_pkg::status_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== hw/rtl/spc_cfg_regs.sv =====
// APB configuration registers of the speaker protection controller.
module spc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spc_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [spc_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [spc_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output spc_pkg::cfg_t                       cfg
);

	spc_pkg::cfg_t    cfg_q;
	spc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = spc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_delay      <= 16'd3000;
			cfg_q.dc_trip_level      <= 16'd2000;
			cfg_q.dc_fast_trip_level <= 16'd5000;
			cfg_q.dc_safe_level      <= 16'd500;
			cfg_q.dc_trip_ticks      <= 16'd500;
			cfg_q.dc_fast_ticks      <= 16'd50;
			cfg_q.overtemp_level     <= 12'd1000;
			cfg_q.cool_reset_level   <= 12'd900;
		end else if (wr_en) begin
			unique case (idx)
				spc_pkg::REG_STARTUP_DELAY: cfg_q.startup_delay      <= pwdata[15:0];
				spc_pkg::REG_DC_TRIP_LEVEL: cfg_q.dc_trip_level      <= pwdata[15:0];
				spc_pkg::REG_DC_FAST_LEVEL: cfg_q.dc_fast_trip_level <= pwdata[15:0];
				spc_pkg::REG_DC_SAFE_LEVEL: cfg_q.dc_safe_level      <= pwdata[15:0];
				spc_pkg::REG_DC_TRIP_TIME:  cfg_q.dc_trip_ticks      <= pwdata[15:0];
				spc_pkg::REG_DC_FAST_TIME:  cfg_q.dc_fast_ticks      <= pwdata[15:0];
				spc_pkg::REG_OVERTEMP:      cfg_q.overtemp_level     <= pwdata[11:0];
				spc_pkg::REG_COOL_RESET:    cfg_q.cool_reset_level   <= pwdata[11:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spc_pkg::REG_STARTUP_DELAY: prdata = {16'd0, cfg_q.startup_delay};
			spc_pkg::REG_DC_TRIP_LEVEL: prdata = {16'd0, cfg_q.dc_trip_level};
			spc_pkg::REG_DC_FAST_LEVEL: prdata = {16'd0, cfg_q.dc_fast_trip_level};
			spc_pkg::REG_DC_SAFE_LEVEL: prdata = {16'd0, cfg_q.dc_safe_level};
			spc_pkg::REG_DC_TRIP_TIME:  prdata = {16'd0, cfg_q.dc_trip_ticks};
			spc_pkg::REG_DC_FAST_TIME:  prdata = {16'd0, cfg_q.dc_fast_ticks};
			spc_pkg::REG_OVERTEMP:      prdata = {20'd0, cfg_q.overtemp_level};
			spc_pkg::REG_COOL_RESET:    prdata = {20'd0, cfg_q.cool_reset_level};
		endcase
	end

endmodule

// ===== hw/rtl/spc_core.sv =====
// Protection state and per-tick update: timers, mute, fault reset, sampling.
module spc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  spc_pkg::tick_word_t   word,
	input  spc_pkg::cfg_t         cfg,
	output spc_pkg::status_word_t result
);

	logic [3:0]  faults_q;
	logic        mute_q;
	logic        done_q;
	logic [15:0] startup_el_q;
	logic [15:0] sample_el_q;
	logic [15:0] persist_cnt_q [2];
	logic [1:0]  persist_act_q;
	logic [11:0] last_temp_q [2];
	logic [15:0] last_dc_q [2];

	logic [3:0]  faults_d;
	logic        mute_d;
	logic        done_d;
	logic [15:0] startup_el_d;
	logic [15:0] sample_el_d;
	logic [15:0] persist_cnt_d [2];
	logic [1:0]  persist_act_d;
	logic [11:0] last_temp_d [2];
	logic [15:0] last_dc_d [2];
	logic        raise;
	logic        reset_ok;
	logic [1:0]  trip;
	logic [16:0] mag [2];
	logic [11:0] reset_limit;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == spc_pkg::SAT16) ? v : v + 16'd1;
	endfunction

	// -32768 comes out as 32768, hence 17 bits
	function automatic logic [16:0] dc_mag(input logic [15:0] raw);
		return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	endfunction

	function automatic logic temp_valid(input logic [11:0] c);
		return (c >= spc_pkg::TEMP_CODE_MIN) && (c <= spc_pkg::TEMP_CODE_MAX);
	endfunction

	function automatic logic temps_ok(input logic [11:0] t0, input logic [11:0] t1,
			input logic [11:0] lim);
		return temp_valid(t0) && temp_valid(t1) && (t0 < lim) && (t1 < lim);
	endfunction

	function automatic logic dc_safe(input logic [15:0] d0, input logic [15:0] d1,
			input logic [15:0] lim);
		return (dc_mag(d0) <= {1'b0, lim}) && (dc_mag(d1) <= {1'b0, lim});
	endfunction

	// reset check sees the samples stored before this tick
	assign reset_limit = (faults_q[2]) ? cfg.cool_reset_level : cfg.overtemp_level;
	assign reset_ok = temps_ok(last_temp_q[0], last_temp_q[1], reset_limit)
		&& dc_safe(last_dc_q[0], last_dc_q[1], cfg.dc_safe_level);

	always_comb begin
		faults_d     = faults_q;
		mute_d       = mute_q ^ word.mute_pressed;
		done_d       = done_q;
		startup_el_d = sat_inc(startup_el_q);
		sample_el_d  = sat_inc(sample_el_q);
		raise        = 1'b0;
		trip         = 2'b00;
		for (int ch = 0; ch < 2; ch++) begin
			persist_cnt_d[ch] = persist_act_q[ch] ? sat_inc(persist_cnt_q[ch])
				: persist_cnt_q[ch];
			last_temp_d[ch]   = last_temp_q[ch];
			last_dc_d[ch]     = last_dc_q[ch];
		end
		persist_act_d = persist_act_q;

		if (word.reset_pressed && (faults_q != 4'd0) && reset_ok) begin
			faults_d      = 4'd0;
			done_d        = 1'b0;
			startup_el_d  = 16'd0;
			persist_act_d = 2'b00;
			for (int ch = 0; ch < 2; ch++) begin
				persist_cnt_d[ch] = 16'd0;
			end
		end

		for (int ch = 0; ch < 2; ch++) begin
			mag[ch] = 17'd0;
		end

		if (sample_el_d >= spc_pkg::SAMPLE_INTERVAL) begin
			sample_el_d = 16'd0;
			if (!word.adc_ok) begin
				faults_d = faults_d | spc_pkg::FLT_ADC;
				raise    = 1'b1;
			end else begin
				last_temp_d[0] = word.temp_one;
				last_temp_d[1] = word.temp_two;
				last_dc_d[0]   = word.dc_left;
				last_dc_d[1]   = word.dc_right;
				if (!temp_valid(word.temp_one)) begin
					faults_d = faults_d | spc_pkg::FLT_SENSOR_ONE;
					raise    = 1'b1;
				end
				if (!temp_valid(word.temp_two)) begin
					faults_d = faults_d | spc_pkg::FLT_SENSOR_TWO;
					raise    = 1'b1;
				end
				if ((word.temp_one >= cfg.overtemp_level)
						|| (word.temp_two >= cfg.overtemp_level)) begin
					faults_d = faults_d | spc_pkg::FLT_HOT;
					raise    = 1'b1;
				end
				// persistence timers, fast level first
				for (int ch = 0; ch < 2; ch++) begin
					mag[ch] = dc_mag(last_dc_d[ch]);
					if ((mag[ch] >= {1'b0, cfg.dc_fast_trip_level})
							|| (mag[ch] >= {1'b0, cfg.dc_trip_level})) begin
						if (!persist_act_d[ch]) begin
							persist_act_d[ch] = 1'b1;
							persist_cnt_d[ch] = 16'd0;
						end
						if (mag[ch] >= {1'b0, cfg.dc_fast_trip_level}) begin
							trip[ch] = persist_cnt_d[ch] >= cfg.dc_fast_ticks;
						end else begin
							trip[ch] = persist_cnt_d[ch] >= cfg.dc_trip_ticks;
						end
					end else begin
						persist_act_d[ch] = 1'b0;
						persist_cnt_d[ch] = 16'd0;
					end
				end
				if (trip != 2'b00) begin
					faults_d = faults_d | spc_pkg::FLT_DC_OFFSET;
					raise    = 1'b1;
				end
			end
			if (raise) begin
				done_d = 1'b0;
			end
			if (!done_d && (faults_d == 4'd0) && (startup_el_d >= cfg.startup_delay)
					&& temps_ok(last_temp_d[0], last_temp_d[1], cfg.overtemp_level)
					&& dc_safe(last_dc_d[0], last_dc_d[1], cfg.dc_safe_level)) begin
				done_d = 1'b1;
			end
		end
	end

	assign result.speakers_on     = (faults_d == 4'd0) && !mute_d && done_d;
	assign result.fault_bits      = faults_d;
	assign result.startup_pending = !done_d && (faults_d == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_q      <= 4'd0;
			mute_q        <= 1'b0;
			done_q        <= 1'b0;
			startup_el_q  <= 16'd0;
			sample_el_q   <= 16'd0;
			persist_act_q <= 2'b00;
			for (int ch = 0; ch < 2; ch++) begin
				persist_cnt_q[ch] <= 16'd0;
				last_temp_q[ch]   <= 12'd0;
				last_dc_q[ch]     <= 16'd0;
			end
		end else if (advance) begin
			faults_q      <= faults_d;
			mute_q        <= mute_d;
			done_q        <= done_d;
			startup_el_q  <= startup_el_d;
			sample_el_q   <= sample_el_d;
			persist_act_q <= persist_act_d;
			for (int ch = 0; ch < 2; ch++) begin
				persist_cnt_q[ch] <= persist_cnt_d[ch];
				last_temp_q[ch]   <= last_temp_d[ch];
				last_dc_q[ch]     <= last_dc_d[ch];
			end
		end
	end

endmodule

// ===== hw/rtl/speaker_protection_controller_top.sv =====
// Speaker protection controller: tick input register, update logic, status output register.
// A tick word waits in the input register until the output register is free; its status
// word is then registered there. Throughput: one tick word per clock while the sink
// takes status words; while a status word waits, the input register can take one new word.
// Reset (arst_n low, asynchronous): faults, mute, startup and DC timers, stored
// samples cleared; registers return to their defaults; no clearing pass is needed.
module speaker_protection_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	spc_tick_if.sink                        tick,
	spc_status_if.source                    status,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [spc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [spc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	spc_pkg::cfg_t         cfg;
	spc_pkg::tick_word_t   word_s1;
	logic                  valid_s1;
	spc_pkg::status_word_t result;
	spc_pkg::status_word_t status_s2;
	logic                  valid_s2;
	logic                  out_free;
	logic                  advance;

	// the output register frees when empty or being taken this cycle
	assign out_free   = !valid_s2 || status.ready;
	// state moves only as a word passes from the input register to the output register
	assign advance    = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || advance;

	spc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word    (word_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			word_s1 <= tick.word;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= result;
		end
	end

	assign status.valid = valid_s2;
	assign status.word  = status_s2;

endmodule

// ===== hw/rtl/spc_checker.sv =====
// Port-level checks of the speaker protection controller, bound to the top level.
module spc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tick_valid,
	input logic       tick_ready,
	input logic       status_valid,
	input logic       status_ready,
	input logic       speakers_on,
	input logic [3:0] fault_bits,
	input logic       startup_pending
);

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid)
		else $error("status word dropped while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> status_valid && !status_ready)
		else $error("tick input stalled without a stalled status word");

	a_fresh_status: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid) |-> $past(tick_valid && tick_ready, 2))
		else $error("status word appeared without a tick word two cycles before");

	a_relay_safe: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && speakers_on |-> (fault_bits == 4'd0) && !startup_pending)
		else $error("speakers connected with a fault or pending startup");

endmodule

bind speaker_protection_controller_top spc_checker u_spc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.tick_valid      (tick.valid),
	.tick_ready      (tick.ready),
	.status_valid    (status.valid),
	.status_ready    (status.ready),
	.speakers_on     (status.word.speakers_on),
	.fault_bits      (status.word.fault_bits),
	.startup_pending (status.word.startup_pending)
);
